FILE: rtl/dsc_pkg.sv
package dsc_pkg;

  // table size default
  localparam int unsigned SlotCountDef = 8;

  // id codes
  localparam logic [31:0] ID_NONE = 32'hffff_ffff;
  localparam logic [31:0] ID_LAST = 32'hffff_fffe;

  // largest chunk the device takes
  localparam logic [8:0] CHUNK_CAP = 9'd256;

  // action codes
  localparam logic [2:0] ACT_ADD_READ  = 3'd0;
  localparam logic [2:0] ACT_ADD_WRITE = 3'd1;
  localparam logic [2:0] ACT_QUERY     = 3'd2;
  localparam logic [2:0] ACT_CLOSE     = 3'd3;
  localparam logic [2:0] ACT_TICK      = 3'd4;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 13;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_CHUNK    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SECTOR_BYTES = 1'd1;
  localparam logic [8:0]  MAX_CHUNK_RST    = 9'd256;
  localparam logic [12:0] SECTOR_BYTES_RST = 13'd512;

  // per slot request record kept in the data memory
  typedef struct packed {
    logic        is_read;
    logic [31:0] buffer;
    logic [31:0] sector;
    logic [31:0] remaining;
  } slot_rec_t;

endpackage

FILE: rtl/dsc_ram.sv
module dsc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 8
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: rtl/disk_request_chunk_scheduler_core.sv
// disk request chunk scheduler
//
// One word enters on the input channel (in_valid_i / in_stall_o) and exactly
// one word leaves on the output channel (out_valid_o / out_stall_i) for it.
// An input word is taken at an edge with in_valid_i high and in_stall_o low.
// The block works on one word at a time; in_stall_o is low only while no
// word is in flight, but a finished word may still sit in the output
// register while the next one is taken.
// Work between acceptance and the result in the output register:
//   add, close, busy tick, empty ready tick, unused action, query of all ones: none
//   ready tick with a held slot: data memory read, multiply, write back
//   query with a held slot: one id memory read per slot, registered compare
// The next word is taken in the cycle after the output load, so the rate is
// set by the id memory sweep for queries and by the chunk read-modify-write for ticks.
// While out_stall_i holds a result, the next result waits in the block and
// in_stall_o stays high. Reset empties the table, clears the id counter,
// phase, close flag and output valid, and loads chunk size 256 and sector size
// 512. Configuration writes are always ready and take effect at once.
module disk_request_chunk_scheduler_core #(
  parameter int unsigned SLOT_COUNT = dsc_pkg::SlotCountDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [dsc_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [dsc_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  // input channel
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [2:0]                       action_i,
  input  logic [31:0]                      buffer_address_i,
  input  logic [31:0]                      start_sector_i,
  input  logic [31:0]                      sector_total_i,
  input  logic [31:0]                      query_id_i,
  input  logic                             device_busy_i,
  // output channel
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [31:0]                      assigned_id_o,
  output logic                             id_pending_o,
  output logic                             manager_closed_o,
  output logic                             issue_valid_o,
  output logic                             issue_is_read_o,
  output logic [31:0]                      issue_start_sector_o,
  output logic [8:0]                       issue_sector_count_o,
  output logic [31:0]                      issue_buffer_address_o
);

  localparam int unsigned IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int unsigned REC_W = $bits(dsc_pkg::slot_rec_t);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_QRY   = 3'd1;
  localparam logic [2:0] S_QLAST = 3'd2;
  localparam logic [2:0] S_TCALC = 3'd3;
  localparam logic [2:0] S_TWR   = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  // control state
  logic [2:0]            state_q, state_d;
  logic [SLOT_COUNT-1:0] held_q, held_d;
  logic [31:0]           last_id_q, last_id_d;
  logic                  busy_q, busy_d;
  logic [IDX_W-1:0]      active_q, active_d;
  logic                  done_q, done_d;
  logic                  closed_q, closed_d;
  logic [8:0]            max_chunk_q;
  logic [12:0]           sector_bytes_q;
  logic                  out_valid_q, out_valid_d;
  logic [IDX_W-1:0]      scan_q, scan_d;
  logic [IDX_W-1:0]      prev_q, prev_d;
  logic                  chk_q, chk_d;

  // payload registers
  logic [31:0]           qid_q, qid_d;
  dsc_pkg::slot_rec_t    rec_q, rec_d;
  logic [8:0]            n_q, n_d;
  logic [21:0]           prod_q, prod_d;
  logic [31:0]           res_id_q, res_id_d;
  logic                  res_pend_q, res_pend_d;
  logic                  res_iv_q, res_iv_d;
  logic                  res_rd_q, res_rd_d;
  logic [31:0]           res_sec_q, res_sec_d;
  logic [8:0]            res_cnt_q, res_cnt_d;
  logic [31:0]           res_buf_q, res_buf_d;
  logic                  out_load;

  // memory ports
  logic                  id_we, dat_we;
  logic [IDX_W-1:0]      id_waddr, id_raddr, dat_waddr, dat_raddr;
  logic [31:0]           id_wdata, id_rdata;
  dsc_pkg::slot_rec_t    dat_wdata, dat_rdata;
  logic [REC_W-1:0]      dat_rdata_raw;

  // table scans over the held bits
  logic [IDX_W-1:0]      free_idx, held_idx;
  logic                  free_any, held_any;
  logic [31:0]           new_id;
  logic [8:0]            cap;
  logic [31:0]           rem_left;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != S_IDLE);
  assign dat_rdata   = dsc_pkg::slot_rec_t'(dat_rdata_raw);

  dsc_ram #(
    .WIDTH (32),
    .DEPTH (SLOT_COUNT)
  ) u_id_ram (
    .clk_i   (clk_i),
    .we_i    (id_we),
    .waddr_i (id_waddr),
    .wdata_i (id_wdata),
    .raddr_i (id_raddr),
    .rdata_o (id_rdata)
  );

  dsc_ram #(
    .WIDTH (REC_W),
    .DEPTH (SLOT_COUNT)
  ) u_dat_ram (
    .clk_i   (clk_i),
    .we_i    (dat_we),
    .waddr_i (dat_waddr),
    .wdata_i (dat_wdata),
    .raddr_i (dat_raddr),
    .rdata_o (dat_rdata_raw)
  );

  // lowest free and lowest held slot
  always_comb begin
    free_idx = '0;
    held_idx = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (!held_q[i]) begin
        free_idx = IDX_W'(i);
      end
      if (held_q[i]) begin
        held_idx = IDX_W'(i);
      end
    end
    free_any = ~&held_q;
    held_any = |held_q;
  end

  // next id, wrapping to zero after the last legal one
  assign new_id = (last_id_q < dsc_pkg::ID_LAST) ? last_id_q + 32'd1 : 32'd0;

  // chunk cap clamped to the device range
  always_comb begin
    if (max_chunk_q == 9'd0) begin
      cap = 9'd1;
    end else if (max_chunk_q > dsc_pkg::CHUNK_CAP) begin
      cap = dsc_pkg::CHUNK_CAP;
    end else begin
      cap = max_chunk_q;
    end
  end

  assign rem_left = rec_q.remaining - {23'd0, n_q};
  assign out_load = (state_q == S_OUT) && (!out_valid_q || !out_stall_i);

  // sequencer
  always_comb begin
    state_d     = state_q;
    held_d      = held_q;
    last_id_d   = last_id_q;
    busy_d      = busy_q;
    active_d    = active_q;
    done_d      = done_q;
    closed_d    = closed_q;
    scan_d      = scan_q;
    prev_d      = prev_q;
    chk_d       = chk_q;
    qid_d       = qid_q;
    rec_d       = rec_q;
    n_d         = n_q;
    prod_d      = prod_q;
    res_id_d    = res_id_q;
    res_pend_d  = res_pend_q;
    res_iv_d    = res_iv_q;
    res_rd_d    = res_rd_q;
    res_sec_d   = res_sec_q;
    res_cnt_d   = res_cnt_q;
    res_buf_d   = res_buf_q;
    out_valid_d = out_valid_q;
    id_we       = 1'b0;
    id_waddr    = free_idx;
    id_wdata    = new_id;
    id_raddr    = scan_q;
    dat_we      = 1'b0;
    dat_waddr   = free_idx;
    dat_wdata   = '{is_read: (action_i == dsc_pkg::ACT_ADD_READ),
                    buffer: buffer_address_i,
                    sector: start_sector_i,
                    remaining: sector_total_i};
    dat_raddr   = held_idx;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          res_id_d   = dsc_pkg::ID_NONE;
          res_pend_d = 1'b0;
          res_iv_d   = 1'b0;
          res_rd_d   = 1'b0;
          res_sec_d  = '0;
          res_cnt_d  = '0;
          res_buf_d  = '0;
          state_d    = S_OUT;
          case (action_i)
            dsc_pkg::ACT_ADD_READ, dsc_pkg::ACT_ADD_WRITE: begin
              if (!closed_q && free_any) begin
                id_we            = 1'b1;
                dat_we           = 1'b1;
                held_d[free_idx] = 1'b1;
                last_id_d        = new_id;
                res_id_d         = new_id;
              end
            end
            dsc_pkg::ACT_QUERY: begin
              qid_d = query_id_i;
              if (query_id_i != dsc_pkg::ID_NONE && held_any) begin
                scan_d  = '0;
                chk_d   = 1'b0;
                state_d = S_QRY;
              end
            end
            dsc_pkg::ACT_CLOSE: begin
              closed_d = 1'b1;
            end
            dsc_pkg::ACT_TICK: begin
              if (!busy_q) begin
                if (held_any) begin
                  active_d = held_idx;
                  state_d  = S_TCALC;
                end
              end else if (!device_busy_i) begin
                if (done_q) begin
                  held_d[active_q] = 1'b0;
                end
                busy_d = 1'b0;
              end
            end
            default: begin
            end
          endcase
        end
      end

      // sweep the id memory, compare in the cycle after each read
      S_QRY: begin
        id_raddr = scan_q;
        prev_d   = scan_q;
        chk_d    = 1'b1;
        if (chk_q && held_q[prev_q] && id_rdata == qid_q) begin
          res_pend_d = 1'b1;
        end
        if (scan_q == IDX_W'(SLOT_COUNT - 1)) begin
          state_d = S_QLAST;
        end else begin
          scan_d = scan_q + IDX_W'(1);
        end
      end

      S_QLAST: begin
        if (held_q[prev_q] && id_rdata == qid_q) begin
          res_pend_d = 1'b1;
        end
        state_d = S_OUT;
      end

      // chunk size and address step from the record just read
      S_TCALC: begin
        rec_d = dat_rdata;
        if (dat_rdata.remaining > {23'd0, cap}) begin
          n_d = cap;
        end else begin
          n_d = dat_rdata.remaining[8:0];
        end
        prod_d  = {13'd0, n_d} * {9'd0, sector_bytes_q};
        state_d = S_TWR;
      end

      // write the advanced record back and report the chunk
      S_TWR: begin
        dat_we    = 1'b1;
        dat_waddr = active_q;
        dat_wdata = '{is_read: rec_q.is_read,
                      buffer: rec_q.buffer + {10'd0, prod_q},
                      sector: rec_q.sector + {23'd0, n_q},
                      remaining: rem_left};
        done_d    = (rem_left == 32'd0);
        busy_d    = 1'b1;
        res_iv_d  = 1'b1;
        res_rd_d  = rec_q.is_read;
        res_sec_d = rec_q.sector;
        res_cnt_d = n_q;
        res_buf_d = rec_q.buffer;
        state_d   = S_OUT;
      end

      S_OUT: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      held_q      <= '0;
      last_id_q   <= '0;
      busy_q      <= 1'b0;
      active_q    <= '0;
      done_q      <= 1'b0;
      closed_q    <= 1'b0;
      out_valid_q <= 1'b0;
      scan_q      <= '0;
      prev_q      <= '0;
      chk_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      held_q      <= held_d;
      last_id_q   <= last_id_d;
      busy_q      <= busy_d;
      active_q    <= active_d;
      done_q      <= done_d;
      closed_q    <= closed_d;
      out_valid_q <= out_valid_d;
      scan_q      <= scan_d;
      prev_q      <= prev_d;
      chk_q       <= chk_d;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_chunk_q    <= dsc_pkg::MAX_CHUNK_RST;
      sector_bytes_q <= dsc_pkg::SECTOR_BYTES_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        dsc_pkg::REG_MAX_CHUNK:    max_chunk_q    <= cfg_data_i[8:0];
        dsc_pkg::REG_SECTOR_BYTES: sector_bytes_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // working payload
  always_ff @(posedge clk_i) begin
    qid_q      <= qid_d;
    rec_q      <= rec_d;
    n_q        <= n_d;
    prod_q     <= prod_d;
    res_id_q   <= res_id_d;
    res_pend_q <= res_pend_d;
    res_iv_q   <= res_iv_d;
    res_rd_q   <= res_rd_d;
    res_sec_q  <= res_sec_d;
    res_cnt_q  <= res_cnt_d;
    res_buf_q  <= res_buf_d;
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      assigned_id_o          <= res_id_q;
      id_pending_o           <= res_pend_q;
      manager_closed_o       <= closed_q && !(|held_q);
      issue_valid_o          <= res_iv_q;
      issue_is_read_o        <= res_rd_q;
      issue_start_sector_o   <= res_sec_q;
      issue_sector_count_o   <= res_cnt_q;
      issue_buffer_address_o <= res_buf_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
